[rtl/qts_pkg.sv]
package qts_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 128;
	localparam int unsigned DATA_W          = 32;

	// command codes
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQUEUED  = 2'd0,
		ST_DEQUEUED  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_XFER,
		S_POP
	} state_t;

endpackage

[rtl/qts_ram.sv]
// simple dual-port RAM, registered read, read data held when not reading
module qts_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/queue_from_two_stacks.sv]
// FIFO queue built from two stacks held in two synchronous RAMs.
// Enqueue, overflow and underflow results are registered from the accepted beat; a dequeue
// passes through the output-stack read register and then the result register, after the input
// stack, if needed, is first moved over at one element per cycle and the last write has landed.
// Throughput: one enqueue per cycle while results drain; a dequeue stalls input until it ends.
// Reset (arst_n low) clears both stack counts and all handshake state; RAMs are not cleared.
module queue_from_two_stacks
	import qts_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic signed [31:0]  value,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  dequeued_value,
	output logic [1:0]          status,
	output logic                queue_empty
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	// stack fill counts
	logic [CW-1:0] in_cnt_q,  in_cnt_d;
	logic [CW-1:0] out_cnt_q, out_cnt_d;

	state_t state_q, state_d;

	// transfer pipeline: set when an input-stack read is in flight
	logic mv_s1, mv_d;

	// RAM ports
	logic              in_we,  in_re;
	logic              out_we, out_re;
	logic [AW-1:0]     in_waddr, in_raddr, out_waddr, out_raddr;
	logic [DATA_W-1:0] in_rdata, out_rdata;

	// result register
	logic              out_valid_q;
	logic [DATA_W-1:0] deq_val_q;
	status_t           status_q;
	logic              empty_q;

	logic              out_free;
	logic              accept;
	logic              load;
	logic [DATA_W-1:0] ld_val;
	status_t           ld_status;
	logic              ld_empty;

	qts_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_in_stack (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_waddr),
		.wdata (value),
		.re    (in_re),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	// output stack is written only from the input stack read data
	qts_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_out_stack (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_waddr),
		.wdata (in_rdata),
		.re    (out_re),
		.raddr (out_raddr),
		.rdata (out_rdata)
	);

	// result slot frees up when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d   = state_q;
		in_cnt_d  = in_cnt_q;
		out_cnt_d = out_cnt_q;
		mv_d      = 1'b0;
		in_we     = 1'b0;
		in_re     = 1'b0;
		out_re    = 1'b0;
		in_waddr  = in_cnt_q[AW-1:0];
		in_raddr  = AW'(in_cnt_q - CW'(1));
		out_raddr = AW'(out_cnt_q - CW'(1));
		// second half of a move: write what was read last cycle
		out_we    = mv_s1;
		out_waddr = out_cnt_q[AW-1:0];
		if (mv_s1) begin
			out_cnt_d = out_cnt_q + CW'(1);
		end
		load      = 1'b0;
		ld_val    = '0;
		ld_status = ST_ENQUEUED;
		ld_empty  = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == CMD_ENQUEUE) begin
						load = 1'b1;
						if (in_cnt_q == CW'(STACK_DEPTH)) begin
							ld_status = ST_OVERFLOW;
						end else begin
							in_we     = 1'b1;
							in_cnt_d  = in_cnt_q + CW'(1);
							ld_status = ST_ENQUEUED;
						end
					end else if (out_cnt_q != '0) begin
						out_re    = 1'b1;
						out_cnt_d = out_cnt_q - CW'(1);
						state_d   = S_POP;
					end else if (in_cnt_q != '0) begin
						state_d = S_XFER;
					end else begin
						load      = 1'b1;
						ld_status = ST_UNDERFLOW;
						ld_empty  = 1'b1;
					end
				end
			end
			S_XFER: begin
				if (in_cnt_q != '0) begin
					in_re    = 1'b1;
					in_cnt_d = in_cnt_q - CW'(1);
					mv_d     = 1'b1;
				end else if (!mv_s1) begin
					// last write has landed, pop the top
					out_re    = 1'b1;
					out_cnt_d = out_cnt_q - CW'(1);
					state_d   = S_POP;
				end
			end
			S_POP: begin
				if (out_free) begin
					load      = 1'b1;
					ld_val    = out_rdata;
					ld_status = ST_DEQUEUED;
					ld_empty  = (in_cnt_q == '0) && (out_cnt_q == '0);
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			mv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			in_cnt_q  <= in_cnt_d;
			out_cnt_q <= out_cnt_d;
			mv_s1     <= mv_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			deq_val_q <= ld_val;
			status_q  <= ld_status;
			empty_q   <= ld_empty;
		end
	end

	assign out_valid      = out_valid_q;
	assign dequeued_value = deq_val_q;
	assign status         = status_q;
	assign queue_empty    = empty_q;

endmodule

[rtl/qts_checker.sv]
module qts_checker
	import qts_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] dequeued_value,
	input logic [1:0]         status,
	input logic               queue_empty
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dequeued_value)
			&& $stable(status) && $stable(queue_empty))
		else $error("result beat changed while stalled");

	// no input beat is taken while a result beat is stuck
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !(in_valid && !in_stall))
		else $error("input beat taken while result stalled");

	a_zero_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DEQUEUED) |-> dequeued_value == '0)
		else $error("nonzero value on a non-dequeue result");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_UNDERFLOW) |-> queue_empty)
		else $error("underflow reported with a non-empty queue");

	a_enq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_ENQUEUED) || (status == ST_OVERFLOW)) |-> !queue_empty)
		else $error("queue reported empty after enqueue or overflow");

endmodule

bind queue_from_two_stacks qts_checker u_qts_checker (.*);

[tb/sv/queue_from_two_stacks_tb.sv]
module queue_from_two_stacks_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qts_pkg::*;

	localparam int DEPTH       = STACK_DEPTH_DEF;
	// The limit only catches a hung handshake.
	localparam int CYCLE_LIMIT = 400000;

	// One reply beat as the block should produce it.
	typedef struct {
		logic [31:0] data;
		status_t     st;
		logic        empty;
	} fifo_reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               command = CMD_ENQUEUE;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] dequeued_value;
	logic [1:0]         status;
	logic               queue_empty;

	// Shadow copy of the two stacks, advanced once per accepted input beat.
	logic [31:0] shadow_in_stack  [DEPTH];
	logic [31:0] shadow_out_stack [DEPTH];
	int          shadow_in_cnt  = 0;
	int          shadow_out_cnt = 0;

	fifo_reply_t fifo_replies_due[$];	// replies owed by the block, oldest first

	int unsigned err_count = 0;
	int unsigned cycles    = 0;
	int          hold_req  = 0;	// receiver hold-off, in cycles, consumed by the stall process
	bit          calm      = 1'b0;	// when set neither side idles at random

	queue_from_two_stacks #(
		.STACK_DEPTH(DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.dequeued_value(dequeued_value),
		.status        (status),
		.queue_empty   (queue_empty)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Watchdog: a stuck handshake ends the run as a failure.
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d replies pending", cycles,
					fifo_replies_due.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Expected reply for one command; updates the shadow stacks.
	// A dequeue with the output stack empty first pours the whole input stack
	// across, which reverses it so the oldest element ends up on top.
	function automatic fifo_reply_t fifo_reply_for(input logic cmd, input logic [31:0] val);
		fifo_reply_t r;
		r.data = '0;
		if (cmd == CMD_ENQUEUE) begin
			// full input stack refuses, whatever room the output stack has
			if (shadow_in_cnt >= DEPTH) begin
				r.st = ST_OVERFLOW;
			end else begin
				shadow_in_stack[shadow_in_cnt] = val;
				shadow_in_cnt++;
				r.st = ST_ENQUEUED;
			end
		end else begin
			if (shadow_out_cnt == 0) begin
				while (shadow_in_cnt > 0) begin
					shadow_in_cnt--;
					shadow_out_stack[shadow_out_cnt] = shadow_in_stack[shadow_in_cnt];
					shadow_out_cnt++;
				end
			end
			if (shadow_out_cnt == 0) begin
				r.st = ST_UNDERFLOW;
			end else begin
				shadow_out_cnt--;
				r.data = shadow_out_stack[shadow_out_cnt];
				r.st = ST_DEQUEUED;
			end
		end
		r.empty = (shadow_in_cnt == 0) && (shadow_out_cnt == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= 30) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	// Mostly random words, with the sign/width corners mixed in.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(15))
			0: begin
				return 32'h8000_0000;
			end
			1: begin
				return 32'h7fff_ffff;
			end
			2: begin
				return 32'h0000_0000;
			end
			3: begin
				return 32'hffff_ffff;
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	// Offer one input beat. Called right after a rising edge, so every drive
	// here lands at the edge. in_valid is left high on return; the next call
	// either keeps it high or drops it while idling, never both in one step.
	task automatic send_op(input logic cmd, input logic [31:0] val);
		while (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= val;
		// pre-edge values are seen here; the beat goes in at the first edge
		// with in_stall low
		do begin
			@(posedge clk);
		end while (in_stall);
		fifo_replies_due.push_back(fifo_reply_for(cmd, val));
	endtask

	// Receiver stall: long hold-offs on request, otherwise random stalls
	// unless the calm window is open.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_req--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 14);
			end
		end
	end

	// Reply checker: every accepted reply beat is matched against the oldest
	// expectation, field by field.
	initial begin
		fifo_reply_t due;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (fifo_replies_due.size() == 0) begin
					report_mismatch($sformatf("unexpected reply beat status=%0d value=%h",
						status, dequeued_value));
				end else begin
					due = fifo_replies_due.pop_front();
					if (status !== due.st)
						report_mismatch($sformatf("status %0d, want %0d", status, due.st));
					if (dequeued_value !== due.data)
						report_mismatch($sformatf("dequeued_value %h, want %h",
							dequeued_value, due.data));
					if (queue_empty !== due.empty)
						report_mismatch($sformatf("queue_empty %b, want %b",
							queue_empty, due.empty));
				end
			end
		end
	end

	// Dequeue from a queue that has never held anything.
	task automatic test_empty_dequeue();
		send_op(CMD_DEQUEUE, 32'hffff_ffff);
		send_op(CMD_DEQUEUE, 32'h0000_0000);
	endtask

	// Corner data values go through in order and come back unchanged;
	// one more dequeue than enqueues ends in underflow.
	task automatic test_extreme_values();
		send_op(CMD_ENQUEUE, 32'h0000_0000);
		send_op(CMD_ENQUEUE, 32'h7fff_ffff);
		send_op(CMD_ENQUEUE, 32'h8000_0000);
		send_op(CMD_ENQUEUE, 32'hffff_ffff);
		send_op(CMD_ENQUEUE, 32'h0000_0001);
		repeat (6) send_op(CMD_DEQUEUE, $urandom());
	endtask

	// FIFO order across transfers: an enqueue while the output stack still
	// holds elements must wait for the next transfer.
	task automatic test_order_across_transfer();
		send_op(CMD_ENQUEUE, 32'h1111_1111);
		send_op(CMD_ENQUEUE, 32'h2222_2222);
		send_op(CMD_DEQUEUE, 32'h0);
		send_op(CMD_ENQUEUE, 32'h3333_3333);
		send_op(CMD_DEQUEUE, 32'h0);
		send_op(CMD_DEQUEUE, 32'h0);
		send_op(CMD_DEQUEUE, 32'h0);
	endtask

	// Fill the input stack to the brim, overflow it, pour it across with a
	// single dequeue, then fill it again while the output stack still holds
	// DEPTH-1 elements: overflow must hit despite the free room there.
	task automatic test_fill_overflow();
		for (int i = 0; i < DEPTH; i++) send_op(CMD_ENQUEUE, rand_word());
		repeat (3) send_op(CMD_ENQUEUE, rand_word());
		send_op(CMD_DEQUEUE, rand_word());
		for (int i = 0; i < DEPTH; i++) send_op(CMD_ENQUEUE, rand_word());
		repeat (2) send_op(CMD_ENQUEUE, rand_word());
		// 2*DEPTH-1 elements held; the last dequeue underflows
		repeat (2 * DEPTH) send_op(CMD_DEQUEUE, rand_word());
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the result register fills and in_stall must come up. Second round
	// does the same across a full transfer.
	task automatic test_backpressure();
		hold_req = 300;
		for (int i = 0; i < 40; i++) send_op(CMD_ENQUEUE, rand_word());
		hold_req = 200;
		repeat (41) send_op(CMD_DEQUEUE, rand_word());
	endtask

	// Random traffic in bursts: each burst has its own enqueue weight, so the
	// fill level wanders from empty (underflows) to full (overflows).
	// The first stretch runs with no idling on either side.
	task automatic test_random_traffic();
		int unsigned enq_pct;
		logic        cmd;
		enq_pct = 50;
		calm = 1'b1;
		for (int i = 0; i < 600; i++) begin
			if (i == 300)
				calm = 1'b0;
			if (i % 40 == 0) begin
				case ($urandom_range(3))
					0: begin
						enq_pct = 15;
					end
					1: begin
						enq_pct = 50;
					end
					2: begin
						enq_pct = 70;
					end
					default: begin
						enq_pct = 97;
					end
				endcase
			end
			cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
			send_op(cmd, rand_word());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_dequeue();
		test_extreme_values();
		test_order_across_transfer();
		test_fill_overflow();
		test_backpressure();
		test_random_traffic();

		in_valid <= 1'b0;
		while (fifo_replies_due.size() != 0) @(posedge clk);
		// a stray reply could still trail a long transfer
		repeat (DEPTH + 8) @(posedge clk);

		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
